// ===== sv/pvl_pkg.sv =====
// Shared types, constants and helpers for the priority voice limiter.
// Used by every module of the block; no dependencies.
package pvl_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int LIMIT_W       = 6;
  localparam int TOTAL_W       = 6;
  localparam int CMP_W         = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_EXIST     = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_DRAIN,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [15:0] source;
    logic [7:0]  prio;
    logic [15:0] aud;
    logic [15:0] age;
  } entry_t;

  // ranking key: prio, audibility, relative age (larger is older)
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] aud;
    logic [15:0] rel;
  } cmp_key_t;

  typedef struct packed {
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    entry_t           mem_data;
    logic             flag_we;
    logic [IDX_W-1:0] flag_addr;
    logic             flag_valid;
    logic             flag_active;
    logic             steal;
    logic [IDX_W-1:0] steal_addr;
  } tbl_wr_t;

  typedef struct packed {
    logic               granted;
    status_t            status;
    logic [TOTAL_W-1:0] active_total;
    logic [TOTAL_W-1:0] virtual_total;
  } result_t;

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [CNT_W-1:0] v);
    logic [CNT_W+TOTAL_W-1:0] wide;
    wide = (CNT_W + TOTAL_W)'(v);
    if (wide > (CNT_W + TOTAL_W)'({TOTAL_W{1'b1}})) begin
      return {TOTAL_W{1'b1}};
    end
    return wide[TOTAL_W-1:0];
  endfunction

endpackage

// ===== sv/pvl_table.sv =====
// Source table: entry memory with registered read, plus valid/active flag flops.
// Depends on pvl_pkg.
module pvl_table (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [pvl_pkg::IDX_W-1:0] rd_addr,
  output pvl_pkg::entry_t       rd_data,
  output logic                  rd_valid,
  output logic                  rd_active,
  input  pvl_pkg::tbl_wr_t      tbl_wr
);
  import pvl_pkg::*;

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] active;
  logic [TABLE_ENTRIES-1:0] active_next;

  // steal and new-entry flag land on different entries in the same commit
  always_comb begin
    active_next = active;
    if (tbl_wr.steal) begin
      active_next[tbl_wr.steal_addr] = 1'b0;
    end
    if (tbl_wr.flag_we) begin
      active_next[tbl_wr.flag_addr] = tbl_wr.flag_active;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_wr.mem_we) begin
      mem[tbl_wr.mem_addr] <= tbl_wr.mem_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      active    <= '0;
      rd_valid  <= 1'b0;
      rd_active <= 1'b0;
    end else begin
      rd_valid  <= valid[rd_addr];
      rd_active <= active[rd_addr];
      active    <= active_next;
      if (tbl_wr.flag_we) begin
        valid[tbl_wr.flag_addr] <= tbl_wr.flag_valid;
      end
    end
  end

endmodule

// ===== sv/pvl_cmp.sv =====
// Shared ranking compare: is key a a worse voice than key b.
// Depends on pvl_pkg.
module pvl_cmp (
  input  pvl_pkg::cmp_key_t a,
  input  pvl_pkg::cmp_key_t b,
  output logic              a_worse
);
  import pvl_pkg::*;

  always_comb begin
    priority if (a.prio != b.prio) begin
      a_worse = a.prio > b.prio;
    end else if (a.aud != b.aud) begin
      a_worse = a.aud < b.aud;
    end else begin
      a_worse = a.rel > b.rel;
    end
  end

endmodule

// ===== sv/pvl_ctrl.sv =====
// Sequencer: walks the table one entry per cycle, then commits the update.
// Depends on pvl_pkg; drives pvl_table and the shared pvl_cmp.
module pvl_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [15:0]                 source_id,
  input  logic [7:0]                  priority_req,
  input  logic [15:0]                 audibility,
  input  logic [pvl_pkg::LIMIT_W-1:0] voice_limit,
  input  logic                        out_free,
  output logic [pvl_pkg::IDX_W-1:0]   rd_addr,
  input  pvl_pkg::entry_t             rd_data,
  input  logic                        rd_valid,
  input  logic                        rd_active,
  output pvl_pkg::tbl_wr_t            tbl_wr,
  output pvl_pkg::cmp_key_t           cmp_a,
  output pvl_pkg::cmp_key_t           cmp_b,
  input  logic                        a_worse,
  output logic                        res_load,
  output pvl_pkg::result_t            result
);
  import pvl_pkg::*;

  ctrl_state_t state, state_next;

  logic [IDX_W-1:0] scan_addr;
  logic             rvalid;
  logic [IDX_W-1:0] ridx;

  op_t         req_op;
  logic [15:0] req_src;
  logic [7:0]  req_prio;
  logic [15:0] req_aud;

  logic             found;
  logic [IDX_W-1:0] match_idx;
  logic [15:0]      match_age;
  logic             match_active;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             worst_found;
  logic [IDX_W-1:0] worst_idx;
  cmp_key_t         worst_key;

  logic [CNT_W-1:0] active_count, active_count_next;
  logic [CNT_W-1:0] virtual_count, virtual_count_next;
  logic [15:0]      stamp, stamp_next;

  cmp_key_t cand_key;
  logic     scan_last;
  logic     below_limit;

  assign cand_key  = '{prio: rd_data.prio, aud: rd_data.aud, rel: stamp - rd_data.age};
  assign scan_last = (scan_addr == IDX_W'(TABLE_ENTRIES - 1));
  assign below_limit = CMP_W'(active_count) < CMP_W'(voice_limit);
  assign rd_addr   = scan_addr;

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE:   if (in_valid) state_next = CS_SCAN;
      CS_SCAN:   if (scan_last) state_next = CS_DRAIN;
      CS_DRAIN:  state_next = CS_FINISH;
      CS_FINISH: if (out_free) state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall           = 1'b1;
    res_load           = 1'b0;
    tbl_wr             = '0;
    cmp_a              = cand_key;
    cmp_b              = worst_key;
    active_count_next  = active_count;
    virtual_count_next = virtual_count;
    stamp_next         = stamp;
    result.granted     = 1'b0;
    result.status      = ST_NOT_FOUND;
    unique case (state)
      CS_IDLE: begin
        in_stall = 1'b0;
      end
      CS_SCAN, CS_DRAIN: begin
      end
      CS_FINISH: begin
        // beats-the-worst check reuses the ranker with ages tied
        cmp_a = worst_key;
        cmp_b = '{prio: req_prio, aud: req_aud, rel: worst_key.rel};
        res_load = out_free;
        if (out_free) begin
          unique case (req_op)
            OP_REQUEST: begin
              if (found) begin
                tbl_wr.mem_we   = 1'b1;
                tbl_wr.mem_addr = match_idx;
                tbl_wr.mem_data = '{source: req_src, prio: req_prio, aud: req_aud,
                                    age: match_age};
                result.granted  = match_active;
                result.status   = ST_EXIST;
              end else if (!free_found) begin
                result.status = ST_FULL;
              end else begin
                tbl_wr.mem_we     = 1'b1;
                tbl_wr.mem_addr   = free_idx;
                tbl_wr.mem_data   = '{source: req_src, prio: req_prio, aud: req_aud,
                                      age: stamp};
                tbl_wr.flag_we    = 1'b1;
                tbl_wr.flag_addr  = free_idx;
                tbl_wr.flag_valid = 1'b1;
                if (below_limit) begin
                  tbl_wr.flag_active = 1'b1;
                  active_count_next  = active_count + 1'b1;
                end else begin
                  // stolen voice turns virtual; active count unchanged
                  tbl_wr.steal       = worst_found && a_worse;
                  tbl_wr.steal_addr  = worst_idx;
                  tbl_wr.flag_active = worst_found && a_worse;
                  virtual_count_next = virtual_count + 1'b1;
                end
                stamp_next     = stamp + 16'd1;
                result.granted = tbl_wr.flag_active;
                result.status  = ST_NEW;
              end
            end
            OP_RELEASE: begin
              if (found) begin
                if (match_active) begin
                  if (active_count != '0) active_count_next = active_count - 1'b1;
                end else begin
                  if (virtual_count != '0) virtual_count_next = virtual_count - 1'b1;
                end
                tbl_wr.flag_we   = 1'b1;
                tbl_wr.flag_addr = match_idx;
                result.status    = ST_RELEASED;
              end
            end
            OP_QUERY: begin
              if (found) begin
                result.granted = match_active;
                result.status  = ST_EXIST;
              end
            end
            OP_UNUSED: begin
            end
          endcase
        end
      end
    endcase
    result.active_total  = sat_total(active_count_next);
    result.virtual_total = sat_total(virtual_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CS_IDLE;
      rvalid        <= 1'b0;
      active_count  <= '0;
      virtual_count <= '0;
      stamp         <= '0;
      found         <= 1'b0;
      free_found    <= 1'b0;
      worst_found   <= 1'b0;
      scan_addr     <= '0;
    end else begin
      state         <= state_next;
      rvalid        <= (state == CS_SCAN);
      active_count  <= active_count_next;
      virtual_count <= virtual_count_next;
      stamp         <= stamp_next;
      if (state == CS_IDLE) begin
        scan_addr   <= '0;
        found       <= 1'b0;
        free_found  <= 1'b0;
        worst_found <= 1'b0;
      end else if (state == CS_SCAN) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (rvalid) begin
        if (rd_valid && rd_data.source == req_src && !found) begin
          found <= 1'b1;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
        end
        if (rd_valid && rd_active && (!worst_found || a_worse)) begin
          worst_found <= 1'b1;
        end
      end
    end
  end

  // request fields and scan captures
  always_ff @(posedge clk) begin
    ridx <= scan_addr;
    if (state == CS_IDLE && in_valid) begin
      req_op   <= op_t'(op);
      req_src  <= source_id;
      req_prio <= priority_req;
      req_aud  <= audibility;
    end
    if (rvalid) begin
      if (rd_valid && rd_data.source == req_src && !found) begin
        match_idx    <= ridx;
        match_age    <= rd_data.age;
        match_active <= rd_active;
      end
      if (!rd_valid && !free_found) begin
        free_idx <= ridx;
      end
      if (rd_valid && rd_active && (!worst_found || a_worse)) begin
        worst_idx <= ridx;
        worst_key <= cand_key;
      end
    end
  end

endmodule

// ===== sv/priority_voice_limiter.sv =====
// Top level of the priority voice limiter: config register, result register,
// sequencer, source table and shared ranker. Depends on pvl_pkg and submodules.
//
//   channel   handshake             payload
//   -------   -------------------   ---------------------------------------------
//   input     in_valid / in_stall   op, source_id, priority_req, audibility
//   output    out_valid / out_stall granted, status, active_total, virtual_total
//   config    cfg_wr_en             cfg_wr_data (voice_limit)
//
// Each request goes through accept, one table read per entry through the single
// memory port, one drain and one commit.
// The commit waits while the previous result is still held and stalled.
// rst (synchronous) empties the table, clears counts and stamp, limit to 16.
// in_stall is high whenever a request is in flight.
module priority_voice_limiter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [15:0]                 source_id,
  input  logic [7:0]                  priority_req,
  input  logic [15:0]                 audibility,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        granted,
  output logic [2:0]                  status,
  output logic [pvl_pkg::TOTAL_W-1:0] active_total,
  output logic [pvl_pkg::TOTAL_W-1:0] virtual_total,
  input  logic                        cfg_wr_en,
  input  logic [pvl_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import pvl_pkg::*;

  logic [LIMIT_W-1:0] voice_limit;
  logic               out_free;
  logic               res_load;
  result_t            result;

  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             rd_valid;
  logic             rd_active;
  tbl_wr_t          tbl_wr;
  cmp_key_t         cmp_a;
  cmp_key_t         cmp_b;
  logic             a_worse;

  // result slot frees up in the same cycle it is taken
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      voice_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      granted       <= result.granted;
      status        <= result.status;
      active_total  <= result.active_total;
      virtual_total <= result.virtual_total;
    end
  end

  pvl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .source_id    (source_id),
    .priority_req (priority_req),
    .audibility   (audibility),
    .voice_limit  (voice_limit),
    .out_free     (out_free),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .rd_valid     (rd_valid),
    .rd_active    (rd_active),
    .tbl_wr       (tbl_wr),
    .cmp_a        (cmp_a),
    .cmp_b        (cmp_b),
    .a_worse      (a_worse),
    .res_load     (res_load),
    .result       (result)
  );

  pvl_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rd_valid  (rd_valid),
    .rd_active (rd_active),
    .tbl_wr    (tbl_wr)
  );

  // one ranker serves both the worst-voice scan and the steal decision
  pvl_cmp u_cmp (
    .a       (cmp_a),
    .b       (cmp_b),
    .a_worse (a_worse)
  );

endmodule

// ===== sv/pvl_checker.sv =====
// Port-level checks for the priority voice limiter, bound to the top level.
// Depends on pvl_pkg.
module pvl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        granted,
  input logic [2:0]                  status,
  input logic [pvl_pkg::TOTAL_W-1:0] active_total,
  input logic [pvl_pkg::TOTAL_W-1:0] virtual_total
);
  import pvl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken while one is in flight");

  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RELEASED || status == ST_NOT_FOUND || status == ST_FULL)
      |-> !granted)
    else $error("grant reported with a non-granting status");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(active_total) + 32'(virtual_total) <= 32'(TABLE_ENTRIES)))
    else $error("counts exceed table size");

endmodule

bind priority_voice_limiter pvl_checker u_pvl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .granted       (granted),
  .status        (status),
  .active_total  (active_total),
  .virtual_total (virtual_total)
);

// ===== tb/priority_voice_limiter_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for priority_voice_limiter: directed, random and backpressure
// traffic checked against an in-bench voice table model. Depends on pvl_pkg and the RTL.
module priority_voice_limiter_test;
  import pvl_pkg::*;

  localparam int SETTLE_CYCLES = 40;       // longer than one request takes
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SLOTS         = 32;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           op;
  logic [15:0]          source_id;
  logic [7:0]           priority_req;
  logic [15:0]          audibility;
  logic                 out_valid;
  logic                 out_stall;
  logic                 granted;
  logic [2:0]           status;
  logic [TOTAL_W-1:0]   active_total;
  logic [TOTAL_W-1:0]   virtual_total;
  logic                 cfg_wr_en;
  logic [LIMIT_W-1:0]   cfg_wr_data;

  priority_voice_limiter DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .source_id     (source_id),
    .priority_req  (priority_req),
    .audibility    (audibility),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted       (granted),
    .status        (status),
    .active_total  (active_total),
    .virtual_total (virtual_total),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Voice table model, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic        slot_used   [SLOTS];
  logic [15:0] slot_source [SLOTS];
  logic [7:0]  slot_prio   [SLOTS];
  logic [15:0] slot_aud    [SLOTS];
  logic        slot_voiced [SLOTS];
  logic [15:0] slot_stamp  [SLOTS];
  logic [15:0] next_stamp;
  int          voiced_count;
  int          virtual_count;
  int          limit_shadow;

  result_t     expected_grants[$];
  int          fail_count;
  int unsigned cycle_count;

  // Idling knobs, changed per traffic phase
  int send_idle_pct;
  int recv_stall_pct;
  int hold_ask;          // nonzero asks the receiver for a long hold-off

  function automatic int find_source(logic [15:0] src);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_source[i] == src) return i;
    return -1;
  endfunction

  // a worse than b: higher prio value, then lower audibility, then older;
  // a full tie keeps the lower index, which the scan visits first
  function automatic bit ranks_below(int a, int b);
    logic [15:0] age_a, age_b;
    age_a = next_stamp - slot_stamp[a];
    age_b = next_stamp - slot_stamp[b];
    if (slot_prio[a] != slot_prio[b]) return slot_prio[a] > slot_prio[b];
    if (slot_aud[a] != slot_aud[b]) return slot_aud[a] < slot_aud[b];
    return age_a > age_b;
  endfunction

  function automatic result_t allocate_voice(op_t o, logic [15:0] src, logic [7:0] pr,
                                             logic [15:0] au);
    result_t r;
    int      hit;
    int      slot;
    int      worst;
    logic    take;
    r.granted = 1'b0;
    r.status  = ST_NOT_FOUND;
    hit = find_source(src);
    case (o)
      OP_REQUEST: begin
        if (hit >= 0) begin
          slot_prio[hit] = pr;
          slot_aud[hit]  = au;
          r.granted = slot_voiced[hit];
          r.status  = ST_EXIST;
        end else begin
          slot = -1;
          for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i] && slot < 0) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            take = 1'b0;
            if (voiced_count < limit_shadow) begin
              take = 1'b1;
              voiced_count++;
            end else begin
              // at or above the limit: try to steal the worst active voice
              worst = -1;
              for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_voiced[i] && (worst < 0 || ranks_below(i, worst)))
                  worst = i;
              if (worst >= 0 && (pr < slot_prio[worst] ||
                                 (pr == slot_prio[worst] && au > slot_aud[worst]))) begin
                slot_voiced[worst] = 1'b0;
                take = 1'b1;
              end
              virtual_count++;
            end
            slot_used[slot]   = 1'b1;
            slot_source[slot] = src;
            slot_prio[slot]   = pr;
            slot_aud[slot]    = au;
            slot_voiced[slot] = take;
            slot_stamp[slot]  = next_stamp;
            next_stamp        = next_stamp + 16'd1;
            r.granted = take;
            r.status  = ST_NEW;
          end
        end
      end
      OP_RELEASE: begin
        if (hit >= 0) begin
          if (slot_voiced[hit]) begin
            if (voiced_count > 0) voiced_count--;
          end else begin
            if (virtual_count > 0) virtual_count--;
          end
          slot_used[hit]   = 1'b0;
          slot_voiced[hit] = 1'b0;
          r.status = ST_RELEASED;
        end
      end
      OP_QUERY: begin
        if (hit >= 0) begin
          r.granted = slot_voiced[hit];
          r.status  = ST_EXIST;
        end
      end
      default: ;
    endcase
    r.active_total  = (voiced_count > 63) ? 6'd63 : TOTAL_W'(voiced_count);
    r.virtual_total = (virtual_count > 63) ? 6'd63 : TOTAL_W'(virtual_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on demand
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result: granted %0d status %0d", granted, status);
        fail_count++;
      end else begin
        want = expected_grants.pop_front();
        if (granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, granted);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (active_total !== want.active_total) begin
          $error("active_total: expected %0d, got %0d", want.active_total, active_total);
          fail_count++;
        end
        if (virtual_total !== want.virtual_total) begin
          $error("virtual_total: expected %0d, got %0d", want.virtual_total, virtual_total);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  // Offer one request; random sender gaps first. Drops valid on the falling
  // edge after the accept so the taken request is not offered again.
  task automatic send_request(op_t o, logic [15:0] src, logic [7:0] pr, logic [15:0] au);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    op           <= o;
    source_id    <= src;
    priority_req <= pr;
    audibility   <= au;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_grants = {expected_grants, allocate_voice(o, src, pr, au)};
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stop offering and wait for every outstanding result, then let the block go idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_voice_limit(int value);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LIMIT_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_shadow = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // empty table: misses and the unused op code
    send_request(OP_QUERY,   16'h0000, 8'd0, 16'h0000);
    send_request(OP_RELEASE, 16'hFFFF, 8'd255, 16'hFFFF);
    send_request(OP_UNUSED,  16'h0000, 8'd0, 16'h0000);
    write_voice_limit(2);
    send_request(OP_REQUEST, 16'h0000, 8'd255, 16'h0000);  // active
    send_request(OP_REQUEST, 16'hFFFF, 8'd255, 16'h0000);  // active, at limit
    send_request(OP_REQUEST, 16'h1111, 8'd255, 16'h0000);  // full tie: no steal
    send_request(OP_REQUEST, 16'h2222, 8'd255, 16'h0001);  // louder: steals oldest tie
    send_request(OP_REQUEST, 16'h3333, 8'd0,   16'hFFFF);  // better prio steals
    send_request(OP_QUERY,   16'h0000, 8'd0,   16'h0000);  // stolen one is virtual
    send_request(OP_QUERY,   16'h3333, 8'd0,   16'h0000);
    send_request(OP_REQUEST, 16'h0000, 8'd0,   16'hFFFF);  // update keeps flag
    send_request(OP_RELEASE, 16'h2222, 8'd0,   16'h0000);  // release active
    send_request(OP_REQUEST, 16'h4444, 8'd128, 16'h8000);  // room again
    send_request(OP_RELEASE, 16'h1111, 8'd0,   16'h0000);  // release virtual
    send_request(OP_UNUSED,  16'h3333, 8'd0,   16'h0000);
    // limit dropped below the active count: only stealing grants
    write_voice_limit(0);
    send_request(OP_REQUEST, 16'h5555, 8'd127, 16'h8000);
    send_request(OP_REQUEST, 16'h6666, 8'd255, 16'hFFFF);
    send_request(OP_RELEASE, 16'h3333, 8'd0,   16'h0000);
    send_request(OP_RELEASE, 16'h5555, 8'd0,   16'h0000);
    // limit 0 and nothing active: always virtual
    send_request(OP_REQUEST, 16'h7777, 8'd0,   16'hFFFF);
    send_request(OP_QUERY,   16'h7777, 8'd0,   16'h0000);
    write_voice_limit(32);
    send_request(OP_REQUEST, 16'hAAAA, 8'h55,  16'h5555);
    send_request(OP_RELEASE, 16'hFFFE, 8'hAA,  16'hAAAA);
    drain_results();
  endtask

  // Random traffic over a small source pool so lookups hit, ranks tie and the
  // table fills; a few ids come from the whole 16-bit range.
  task automatic test_random_traffic(int send_pct, int recv_pct, int limit, int count,
                                     int release_pct);
    logic [15:0] pool[64];
    int          pool_n;
    int          pick;
    op_t         o;
    logic [15:0] src;
    logic [7:0]  pr;
    logic [15:0] au;
    write_voice_limit(limit);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    pool_n = $urandom_range(36, 56);
    foreach (pool[i]) pool[i] = 16'($urandom_range(65535));
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < release_pct)           o = OP_RELEASE;
      else if (pick < release_pct + 15) o = OP_QUERY;
      else if (pick < release_pct + 19) o = OP_UNUSED;
      else                              o = OP_REQUEST;
      if ($urandom_range(19) == 0) src = 16'($urandom_range(65535));
      else                         src = pool[6'($urandom_range(pool_n - 1))];
      pr = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      case ($urandom_range(5))
        0:       au = 16'h0000;
        1:       au = 16'hFFFF;
        2:       au = 16'($urandom_range(2));
        default: au = 16'($urandom_range(65535));
      endcase
      send_request(o, src, pr, au);
    end
    drain_results();
  endtask

  // Receiver holds off long enough that the block backs up onto its input
  task automatic test_backpressure();
    write_voice_limit(3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ask = 300;
    for (int n = 0; n < 12; n++)
      send_request(OP_REQUEST, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                   16'($urandom_range(65535)));
    // sender pauses until everything is back, then a short burst
    drain_results();
    for (int n = 0; n < 6; n++)
      send_request(n[0] ? OP_QUERY : OP_RELEASE, 16'($urandom_range(65535)),
                   8'($urandom_range(255)), 16'($urandom_range(65535)));
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_REQUEST;
    source_id      = '0;
    priority_req   = '0;
    audibility     = '0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ask       = 0;
    fail_count     = 0;
    cycle_count    = 0;
    next_stamp     = '0;
    voiced_count   = 0;
    virtual_count  = 0;
    limit_shadow   = int'(LIMIT_RESET);
    foreach (slot_used[i]) begin
      slot_used[i]   = 1'b0;
      slot_voiced[i] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_directed_cases();
    test_random_traffic(0,  0,  16, 300, 30);
    test_random_traffic(51, 0,  32, 300, 10);   // few releases: table runs full
    test_random_traffic(0,  51, 4,  300, 30);
    test_random_traffic(10, 10, 1,  300, 25);
    test_random_traffic(0,  0,  0,  250, 30);
    test_random_traffic(51, 0,  8,  300, 20);
    test_backpressure();

    drain_results();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pvl_pkg.sv
sv/pvl_table.sv
sv/pvl_cmp.sv
sv/pvl_ctrl.sv
sv/priority_voice_limiter.sv
sv/pvl_checker.sv
tb/priority_voice_limiter_test.sv
